[rtl/tone_cycle_count_demodulator_unit_assert.svh]
// ----------------------------------------------------------------------------
// Tone cycle count demodulator assertion macros
// Clocked concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TONE_CYCLE_COUNT_DEMODULATOR_UNIT_ASSERT_SVH
`define TONE_CYCLE_COUNT_DEMODULATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TCCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tccd_pkg.sv]
// ----------------------------------------------------------------------------
// tccd_pkg
// Types, codes and reset constants shared by the tone cycle count demodulator.
// ----------------------------------------------------------------------------
package tccd_pkg;

  localparam int unsigned SAMPLE_W    = 10;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned USEC_PER_MS = 1000;
  localparam int unsigned LIMIT_W     = 26;  // 65535 * 1000 fits in 26 bits
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned BYTE_W      = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
  localparam logic [COUNT_W-1:0] COUNT_LO  = 4'd2;
  localparam logic [COUNT_W-1:0] COUNT_HI  = 4'd5;

  localparam logic [SAMPLE_W-1:0]   RST_LOW_THR    = 10'd350;
  localparam logic [SAMPLE_W-1:0]   RST_HIGH_THR   = 10'd600;
  localparam int unsigned           RST_TIMEOUT_MS = 1000;
  localparam logic [LIMIT_W-1:0]    RST_TIMEOUT_LIMIT = LIMIT_W'(RST_TIMEOUT_MS * USEC_PER_MS);
  localparam logic [CFG_DATA_W-1:0] RST_GAP_US     = 16'd8000;
  localparam logic [CFG_DATA_W-1:0] RST_MIN_SYM_US = 16'd3500;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_LOW_THR    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_THR   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_MS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAP_US     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SYM_US = 3'd4;

  // Request opcodes
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Result status codes
  localparam logic STATUS_BYTE    = 1'b0;
  localparam logic STATUS_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    ZONE_LOW  = 2'd0,
    ZONE_MID  = 2'd1,
    ZONE_HIGH = 2'd2
  } zone_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]   low_thr;
    logic [SAMPLE_W-1:0]   high_thr;
    logic [LIMIT_W-1:0]    timeout_limit;  // timeout in microseconds
    logic [CFG_DATA_W-1:0] gap_us;
    logic [CFG_DATA_W-1:0] min_sym_us;
  } cfg_t;

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   now_us;
  } item_t;

  typedef struct packed {
    logic               waiting;
    logic [TIME_W-1:0]  wait_start_time;
    zone_t              previous_zone;
    logic               tone_seen;
    logic               tone_started;
    logic [TIME_W-1:0]  tone_start_time;
    logic [COUNT_W-1:0] crossing_count;
    logic [BYTE_W-1:0]  partial_byte;
    logic [1:0]         symbol_count;
  } dec_state_t;

  typedef struct packed {
    logic              valid;
    logic              status;
    logic [BYTE_W-1:0] byte_value;
  } result_t;

  localparam dec_state_t DEC_STATE_RST = '{
    waiting:         1'b0,
    wait_start_time: '0,
    previous_zone:   ZONE_MID,
    tone_seen:       1'b0,
    tone_started:    1'b0,
    tone_start_time: '0,
    crossing_count:  '0,
    partial_byte:    '0,
    symbol_count:    '0
  };

endpackage

[rtl/tccd_step.sv]
// ----------------------------------------------------------------------------
// tccd_step
// Next decoder state and optional result for one registered request.
// ----------------------------------------------------------------------------
module tccd_step
  import tccd_pkg::*;
(
  input  dec_state_t state_cur,
  input  cfg_t       cfg,
  input  item_t      item,
  output dec_state_t state_nxt,
  output result_t    result
);

  logic [TIME_W-1:0]  wait_el;
  logic [TIME_W-1:0]  tone_el;
  logic               alive;
  zone_t              zone;
  logic               count_ok;
  logic [1:0]         sym;
  logic [BYTE_W-1:0]  pb_shift;
  logic [1:0]         sc_inc;

  assign wait_el  = item.now_us - state_cur.wait_start_time;
  assign tone_el  = item.now_us - state_cur.tone_start_time;
  assign alive    = (wait_el < TIME_W'(cfg.timeout_limit)) ||
                    (state_cur.tone_started && (tone_el < TIME_W'(cfg.gap_us)));
  assign count_ok = (state_cur.crossing_count >= COUNT_LO) &&
                    (state_cur.crossing_count <= COUNT_HI);
  assign sym      = 2'(state_cur.crossing_count - COUNT_LO);
  assign pb_shift = {state_cur.partial_byte[BYTE_W-3:0], sym};
  assign sc_inc   = state_cur.symbol_count + 2'd1;

  always_comb begin
    priority if (item.sample <= cfg.low_thr) begin
      zone = ZONE_LOW;
    end else if (item.sample <= cfg.high_thr) begin
      zone = ZONE_MID;
    end else begin
      zone = ZONE_HIGH;
    end
  end

  always_comb begin
    state_nxt = state_cur;
    result    = '{valid: 1'b0, status: STATUS_BYTE, byte_value: '0};
    if (item.op == OP_START) begin
      state_nxt                 = DEC_STATE_RST;
      state_nxt.waiting         = 1'b1;
      state_nxt.wait_start_time = item.now_us;
    end else if (!state_cur.waiting) begin
      // drop samples outside a wait
    end else if (!alive) begin
      state_nxt.waiting = 1'b0;
      result = '{valid: 1'b1, status: STATUS_TIMEOUT, byte_value: '0};
    end else if (zone != state_cur.previous_zone) begin
      state_nxt.previous_zone = zone;
      if (zone == ZONE_HIGH) begin
        if (!state_cur.tone_seen) begin
          state_nxt.tone_start_time = item.now_us;
          state_nxt.tone_started    = 1'b1;
        end else if (tone_el > TIME_W'(cfg.gap_us)) begin
          // tone gap: restart byte assembly
          state_nxt.tone_start_time = item.now_us;
          state_nxt.crossing_count  = '0;
          state_nxt.partial_byte    = '0;
          state_nxt.symbol_count    = '0;
        end
      end else if (zone == ZONE_MID && state_cur.previous_zone == ZONE_HIGH) begin
        if (state_cur.crossing_count != COUNT_MAX) begin
          state_nxt.crossing_count = state_cur.crossing_count + 4'd1;
        end
        state_nxt.tone_seen = 1'b1;
      end else if (zone == ZONE_MID && state_cur.previous_zone == ZONE_LOW) begin
        if (state_cur.tone_seen && (tone_el > TIME_W'(cfg.min_sym_us))) begin
          state_nxt.tone_seen      = 1'b0;
          state_nxt.crossing_count = '0;
          if (count_ok) begin
            state_nxt.partial_byte = pb_shift;
            state_nxt.symbol_count = sc_inc;
            if (sc_inc == 2'd0) begin
              state_nxt.partial_byte = '0;
              if (pb_shift != '0) begin
                // byte done: tone flag and count are left as they are
                state_nxt.waiting        = 1'b0;
                state_nxt.tone_seen      = state_cur.tone_seen;
                state_nxt.crossing_count = state_cur.crossing_count;
                result = '{valid: 1'b1, status: STATUS_BYTE, byte_value: pb_shift};
              end
            end
          end
        end
      end
    end
  end

endmodule

[rtl/tone_cycle_count_demodulator_unit.sv]
// ----------------------------------------------------------------------------
// tone_cycle_count_demodulator_unit
// Sorts timestamped converter samples into zones, counts tone crossings per
// symbol, packs 2-bit symbols into bytes and reports a byte or a timeout.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   in_     | input     | in_valid/in_ready  | in_op, in_sample, in_now_us
//   out_    | output    | out_valid/out_ready| out_status, out_byte_value
//   cfg_    | input     | cfg_we (no wait)   | cfg_index, cfg_wdata
//
// One request per cycle sustained while the output register does not stall. A
// request is held in the input register, and its result is loaded into the
// output register when the request is processed.
// The stall point is the output register: a waiting result blocks only a
// request that itself produces a result; others keep flowing.
// Reset (synchronous, rst_n low) clears the decoder, ends any wait and loads
// the default register values. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "tone_cycle_count_demodulator_unit_assert.svh"

module tone_cycle_count_demodulator_unit
  import tccd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // request channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_op,
  input  logic [SAMPLE_W-1:0]    in_sample,
  input  logic [TIME_W-1:0]      in_now_us,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_status,
  output logic [BYTE_W-1:0]      out_byte_value
);

  cfg_t       cfg_r;
  item_t      in_item_r;
  logic       in_vld_r;
  dec_state_t state_r;
  dec_state_t state_nxt;
  result_t    step_res;
  logic       out_vld_r;
  logic       out_status_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic       fire;

  // Configuration registers. Store the timeout already scaled to
  // microseconds so the datapath only compares.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_thr       <= RST_LOW_THR;
      cfg_r.high_thr      <= RST_HIGH_THR;
      cfg_r.timeout_limit <= RST_TIMEOUT_LIMIT;
      cfg_r.gap_us        <= RST_GAP_US;
      cfg_r.min_sym_us    <= RST_MIN_SYM_US;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW_THR:    cfg_r.low_thr       <= cfg_wdata[SAMPLE_W-1:0];
        CFG_HIGH_THR:   cfg_r.high_thr      <= cfg_wdata[SAMPLE_W-1:0];
        CFG_TIMEOUT_MS: cfg_r.timeout_limit <= LIMIT_W'(cfg_wdata) *
                                               LIMIT_W'(USEC_PER_MS);
        CFG_GAP_US:     cfg_r.gap_us        <= cfg_wdata;
        CFG_MIN_SYM_US: cfg_r.min_sym_us    <= cfg_wdata;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // Process the held request unless it has a result and the output
  // register is still occupied.
  assign fire     = in_vld_r && (!step_res.valid || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= '{op: in_op, sample: in_sample, now_us: in_now_us};
    end
  end

  tccd_step u_step (
    .state_cur (state_r),
    .cfg       (cfg_r),
    .item      (in_item_r),
    .state_nxt (state_nxt),
    .result    (step_res)
  );

  // Decoder state: advance only on a processed request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DEC_STATE_RST;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // Output register: load a new result, drop the old one once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && step_res.valid) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step_res.valid) begin
      out_status_r <= step_res.status;
      out_byte_r   <= step_res.byte_value;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_status     = out_status_r;
  assign out_byte_value = out_byte_r;

  // Checks
  `TCCD_ASSERT_NOW(a_timeout_zero_byte, out_vld_r && (out_status_r == STATUS_TIMEOUT), out_byte_r == '0, "timeout result carries a nonzero byte")
  `TCCD_ASSERT_NOW(a_byte_nonzero, out_vld_r && (out_status_r == STATUS_BYTE), out_byte_r != '0, "byte result is zero")
  `TCCD_ASSERT_NEXT(a_result_ends_wait, fire && step_res.valid, !state_r.waiting && out_vld_r, "result did not end the wait")

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Tone cycle count demodulator testbench
// Feeds start and sample requests to the demodulator, predicts each byte or
// timeout outcome with an in-bench model of the decoder, and checks every
// result field by field. The run moves through several register settings
// (defaults, wide and narrow zones, crossed thresholds, zero and maximum
// timers) and several idling patterns on both channels.
// ----------------------------------------------------------------------------
module testbench
  import tccd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] byte_value;
  } demod_outcome_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  // block ports, all known from time zero
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_op = OP_START;
  logic [SAMPLE_W-1:0]    in_sample = '0;
  logic [TIME_W-1:0]      in_now_us = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_status;
  logic [BYTE_W-1:0]      out_byte_value;

  tone_cycle_count_demodulator_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_sample     (in_sample),
    .in_now_us     (in_now_us),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_byte_value(out_byte_value)
  );

  // Requests waiting to be driven, and outcomes waiting to arrive.
  item_t          pending_req_q[$];
  demod_outcome_t expected_outcome_q[$];

  int unsigned pushed_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned fail_cnt = 0;

  // Idling: percentage of cycles the sender holds off / the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Register copies, shared by the predictor and the stimulus shaping.
  logic [SAMPLE_W-1:0]   thr_lo = RST_LOW_THR;
  logic [SAMPLE_W-1:0]   thr_hi = RST_HIGH_THR;
  logic [CFG_DATA_W-1:0] wait_ms = CFG_DATA_W'(RST_TIMEOUT_MS);
  logic [CFG_DATA_W-1:0] gap_lim_us = RST_GAP_US;
  logic [CFG_DATA_W-1:0] min_sym_lim_us = RST_MIN_SYM_US;

  // Decoder state as the predictor sees it.
  logic               dec_waiting = 1'b0;
  logic [TIME_W-1:0]  dec_wait_t0 = '0;
  zone_t              dec_prev_zone = ZONE_MID;
  logic               dec_tone_seen = 1'b0;
  logic               dec_tone_started = 1'b0;
  logic [TIME_W-1:0]  dec_tone_t0 = '0;
  logic [COUNT_W-1:0] dec_cycles = '0;
  logic [BYTE_W-1:0]  dec_acc_byte = '0;
  logic [1:0]         dec_nsym = '0;

  // Stimulus timeline and per-phase sample spacing.
  logic [TIME_W-1:0] now_t = '0;
  int unsigned       step_lo = 750;
  int unsigned       step_hi = 1000;

  item_t drv_req;

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(input string what);
    fail_cnt++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Advance the decoder model by one accepted request; queue its outcome if
  // it makes one.
  task automatic demod_predict(input logic opc, input logic [SAMPLE_W-1:0] smp,
                               input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] since_wait;
    logic [TIME_W-1:0] since_tone;
    longint unsigned   wait_lim;
    logic              alive;
    zone_t             zn;

    // A start (re)opens the wait and clears the decoder.
    if (opc == OP_START) begin
      dec_waiting = 1'b1;
      dec_wait_t0 = now;
      dec_prev_zone = ZONE_MID;
      dec_tone_seen = 1'b0;
      dec_tone_started = 1'b0;
      dec_tone_t0 = '0;
      dec_cycles = '0;
      dec_acc_byte = '0;
      dec_nsym = '0;
      return;
    end
    // Drop samples while no wait is open.
    if (!dec_waiting)
      return;

    // The wait lives on its own timer or while the current tone is fresh.
    since_wait = now - dec_wait_t0;
    since_tone = now - dec_tone_t0;
    wait_lim = longint'(wait_ms) * USEC_PER_MS;
    alive = (longint'(since_wait) < wait_lim);
    if (dec_tone_started && since_tone < TIME_W'(gap_lim_us))
      alive = 1'b1;
    if (!alive) begin
      dec_waiting = 1'b0;
      expected_outcome_q.push_back('{status: STATUS_TIMEOUT, byte_value: '0});
      return;
    end

    if (smp <= thr_lo)
      zn = ZONE_LOW;
    else if (smp <= thr_hi)
      zn = ZONE_MID;
    else
      zn = ZONE_HIGH;
    if (zn == dec_prev_zone)
      return;

    if (zn == ZONE_HIGH) begin
      // Start a tone, or restart assembly when the tone has gone stale.
      if (!dec_tone_seen) begin
        dec_tone_t0 = now;
        dec_tone_started = 1'b1;
      end else if (since_tone > TIME_W'(gap_lim_us)) begin
        dec_tone_t0 = now;
        dec_cycles = '0;
        dec_acc_byte = '0;
        dec_nsym = '0;
      end
    end else if (zn == ZONE_MID && dec_prev_zone == ZONE_HIGH) begin
      if (dec_cycles != COUNT_MAX)
        dec_cycles = dec_cycles + 1'b1;
      dec_tone_seen = 1'b1;
    end else if (zn == ZONE_MID && dec_prev_zone == ZONE_LOW) begin
      // Close the symbol once the tone has lasted long enough.
      if (dec_tone_seen && since_tone > TIME_W'(min_sym_lim_us)) begin
        if (dec_cycles >= COUNT_LO && dec_cycles <= COUNT_HI) begin
          dec_acc_byte = {dec_acc_byte[BYTE_W-3:0], 2'(dec_cycles - COUNT_LO)};
          dec_nsym = dec_nsym + 1'b1;
          if (dec_nsym == 2'd0) begin
            if (dec_acc_byte != '0) begin
              expected_outcome_q.push_back('{status: STATUS_BYTE,
                                             byte_value: dec_acc_byte});
              dec_waiting = 1'b0;
              dec_prev_zone = zn;
              dec_acc_byte = '0;
              return;
            end
            dec_acc_byte = '0;
          end
        end
        dec_tone_seen = 1'b0;
        dec_cycles = '0;
      end
    end
    dec_prev_zone = zn;
  endtask

  // Driver: load the next request whenever the channel is free, idling at
  // random; predict each request at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        demod_predict(in_op, in_sample, in_now_us);
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_req = pending_req_q.pop_front();
          in_valid  <= 1'b1;
          in_op     <= drv_req.op;
          in_sample <= drv_req.sample;
          in_now_us <= drv_req.now_us;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expected outcome,
  // then pick the next cycle's ready at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_outcome_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result status %0b byte %02h",
                                  out_status, out_byte_value));
        end else begin
          if (out_status !== expected_outcome_q[0].status)
            flag_mismatch($sformatf("status %0b, expected %0b", out_status,
                                    expected_outcome_q[0].status));
          if (out_byte_value !== expected_outcome_q[0].byte_value)
            flag_mismatch($sformatf("byte %02h, expected %02h", out_byte_value,
                                    expected_outcome_q[0].byte_value));
          void'(expected_outcome_q.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---- stimulus helpers ----

  // Queue one request, advancing the timeline by dt microseconds.
  task automatic push_req(input logic opc, input logic [SAMPLE_W-1:0] smp,
                          input logic [TIME_W-1:0] dt);
    now_t = now_t + dt;
    pending_req_q.push_back('{op: opc, sample: smp, now_us: now_t});
    pushed_cnt++;
  endtask

  // Pick a reading inside a zone under the current thresholds; fall back to
  // any reading when the zone is empty.
  function automatic logic [SAMPLE_W-1:0] zone_sample(input zone_t z);
    int unsigned top;
    top = (thr_lo > thr_hi) ? int'(thr_lo) : int'(thr_hi);
    case (z)
      ZONE_LOW: return SAMPLE_W'($urandom_range(0, int'(thr_lo)));
      ZONE_MID: begin
        if (thr_lo < thr_hi)
          return SAMPLE_W'($urandom_range(int'(thr_lo) + 1, int'(thr_hi)));
      end
      default: begin
        if (top < 1023)
          return SAMPLE_W'($urandom_range(top + 1, 1023));
      end
    endcase
    return SAMPLE_W'($urandom_range(1023));
  endfunction

  // One sample in a zone, sometimes followed by a repeat that stays in it.
  task automatic push_zone(input zone_t z);
    push_req(OP_SAMPLE, zone_sample(z), $urandom_range(step_lo, step_hi));
    if ($urandom_range(99) < 8)
      push_req(OP_SAMPLE, zone_sample(z), $urandom_range(step_lo, step_hi));
  endtask

  // One symbol: n high-to-middle crossings, then low and back to middle.
  task automatic gen_symbol(input int unsigned n_cross);
    for (int unsigned i = 0; i < n_cross; i++) begin
      push_zone(ZONE_HIGH);
      push_zone(ZONE_MID);
    end
    push_zone(ZONE_LOW);
    push_zone(ZONE_MID);
  endtask

  // A start followed by four or five symbols, with noise mixed in:
  // stray samples while idle, restarts, wild readings and long silences.
  task automatic gen_frame();
    int unsigned n_sym;
    int unsigned roll;
    if ($urandom_range(99) < 10)
      push_req(OP_SAMPLE, SAMPLE_W'($urandom_range(1023)), $urandom_range(1, step_hi));
    if ($urandom_range(99) < 30)
      now_t = $urandom();
    push_req(OP_START, SAMPLE_W'($urandom_range(1023)), $urandom_range(1, step_hi));
    n_sym = ($urandom_range(99) < 20) ? 5 : 4;
    for (int unsigned k = 0; k < n_sym; k++) begin
      roll = $urandom_range(99);
      if (roll < 4)
        push_req(OP_SAMPLE, zone_sample(ZONE_MID),
                 TIME_W'(longint'(wait_ms) * USEC_PER_MS + gap_lim_us +
                         $urandom_range(1, 1000)));
      else if (roll < 7)
        push_req(OP_START, SAMPLE_W'($urandom_range(1023)), $urandom_range(1, step_hi));
      else if (roll < 12)
        push_req(OP_SAMPLE, SAMPLE_W'($urandom_range(1023)),
                 $urandom_range(step_lo, step_hi));
      gen_symbol(($urandom_range(99) < 80) ? $urandom_range(5, 2) : $urandom_range(17, 0));
    end
  endtask

  // Wait until every request is through and every outcome has arrived, then
  // let the pipeline settle.
  task automatic wait_drained();
    do
      @(posedge clk);
    while (accepted_cnt != pushed_cnt || expected_outcome_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Write one register and keep the predictor's copy in step.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_LOW_THR:    thr_lo = val[SAMPLE_W-1:0];
      CFG_HIGH_THR:   thr_hi = val[SAMPLE_W-1:0];
      CFG_TIMEOUT_MS: wait_ms = val;
      CFG_GAP_US:     gap_lim_us = val;
      CFG_MIN_SYM_US: min_sym_lim_us = val;
      default: ;
    endcase
  endtask

  // Drain, reprogram all registers, set spacing and idling, then queue
  // random frames until this phase's share of requests is in.
  task automatic run_phase(input int unsigned lo, input int unsigned hi,
                           input int unsigned tmo, input int unsigned gap,
                           input int unsigned min_sym, input int unsigned slo,
                           input int unsigned shi, input int unsigned sidle,
                           input int unsigned rstall, input int unsigned n_req);
    int unsigned target;
    wait_drained();
    write_reg(CFG_LOW_THR, CFG_DATA_W'(lo));
    write_reg(CFG_HIGH_THR, CFG_DATA_W'(hi));
    write_reg(CFG_TIMEOUT_MS, CFG_DATA_W'(tmo));
    write_reg(CFG_GAP_US, CFG_DATA_W'(gap));
    write_reg(CFG_MIN_SYM_US, CFG_DATA_W'(min_sym));
    @(posedge clk);
    cfg_we <= 1'b0;
    step_lo = slo;
    step_hi = shi;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    target = pushed_cnt + n_req;
    while (pushed_cnt < target)
      gen_frame();
  endtask

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset register values.
    now_t = 32'hFFFF_F000;
    push_req(OP_SAMPLE, 10'h3FF, 0);        // sample while idle: ignored
    push_req(OP_START, 10'h2AA, 100);
    // symbol of two crossings straddling the time wrap, zone edges exercised
    push_req(OP_SAMPLE, 10'd601, 800);
    push_req(OP_SAMPLE, 10'd600, 800);
    push_req(OP_SAMPLE, 10'h3FF, 800);
    push_req(OP_SAMPLE, 10'd351, 800);
    push_req(OP_SAMPLE, 10'd350, 800);
    push_req(OP_SAMPLE, 10'd0, 100);        // same zone again: no change
    push_req(OP_SAMPLE, 10'd500, 800);      // closes symbol 0
    // a single crossing is too few: dropped
    push_req(OP_SAMPLE, 10'd700, 300);
    push_req(OP_SAMPLE, 10'd400, 300);
    push_req(OP_SAMPLE, 10'd10, 300);
    push_req(OP_SAMPLE, 10'd400, 3000);
    // two crossings, but too short to close
    push_req(OP_SAMPLE, 10'd900, 200);
    push_req(OP_SAMPLE, 10'd450, 200);
    push_req(OP_SAMPLE, 10'd800, 200);
    push_req(OP_SAMPLE, 10'd450, 200);
    push_req(OP_SAMPLE, 10'd100, 200);
    push_req(OP_SAMPLE, 10'd450, 200);
    push_req(OP_SAMPLE, 10'd400, 2_000_000); // long silence: timeout
    push_req(OP_SAMPLE, 10'd700, 10);        // idle again: ignored
    push_req(OP_START, 10'h155, 10);
    push_req(OP_START, 10'h000, 10);         // start while waiting

    // lo, hi, timeout_ms, gap, min_sym, step range, send idle, recv stall, requests
    run_phase(350, 600, 1000, 8000, 3500, 750, 1000, 0, 0, 400);
    run_phase(100, 900, 65535, 65535, 0, 1, 400, 57, 0, 300);
    run_phase(500, 501, 5, 2000, 65535, 100, 600, 0, 57, 150);
    run_phase(0, 1022, 2, 0, 200, 50, 300, 36, 36, 250);
    run_phase(700, 300, 0, 0, 0, 10, 100, 36, 36, 150);
    run_phase(1022, 1023, 65535, 100, 50, 1, 50, 57, 57, 80);
    run_phase($urandom_range(200, 400), $urandom_range(500, 800), 50, 6000, 3000,
              700, 1000, 36, 36, 470);

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
